// ===== src/lrcps_pkg.sv =====
// ----------------------------------------------------------------------------
// lrcps_pkg
// Shared types, codes and palette for the LED ring chase pattern sequencer.
// ----------------------------------------------------------------------------
package lrcps_pkg;

  // palette size, between 1 and 8
  localparam int unsigned PALETTE_ENTRIES = 7;

  localparam int unsigned TIME_W  = 32;
  localparam int unsigned DELAY_W = 16;
  localparam int unsigned PIX_W   = 8;
  localparam int unsigned CHAN_W  = 8;
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned CIDX_W  = 3;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned CFG_IDX_W = 2;

  // output command codes
  localparam logic [CMD_W-1:0] CMD_NONE  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SET   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LED_COUNT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHASE_DELAY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_DELAY  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFF_DELAY   = 2'd3;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } colour_t;

  // fixed colour table, the eighth slot is black
  function automatic colour_t palette(input logic [CIDX_W-1:0] idx);
    colour_t c;
    case (idx)
      3'd0:    c = '{red: 8'd255, green: 8'd32,  blue: 8'd32};
      3'd1:    c = '{red: 8'd32,  green: 8'd255, blue: 8'd80};
      3'd2:    c = '{red: 8'd32,  green: 8'd64,  blue: 8'd255};
      3'd3:    c = '{red: 8'd255, green: 8'd180, blue: 8'd32};
      3'd4:    c = '{red: 8'd255, green: 8'd32,  blue: 8'd180};
      3'd5:    c = '{red: 8'd32,  green: 8'd255, blue: 8'd255};
      3'd6:    c = '{red: 8'd255, green: 8'd255, blue: 8'd255};
      default: c = '{red: 8'd0,   green: 8'd0,   blue: 8'd0};
    endcase
    return c;
  endfunction

endpackage

// ===== src/lrcps_tick_if.sv =====
// ----------------------------------------------------------------------------
// lrcps_tick_if
// Timestamp channel: valid/ready handshake carrying the millisecond count.
// ----------------------------------------------------------------------------
interface lrcps_tick_if;
  logic                              valid;
  logic                              ready;
  logic [lrcps_pkg::TIME_W-1:0]      now_ms;

  modport source (output valid, output now_ms, input ready);
  modport sink   (input valid, input now_ms, output ready);
endinterface

// ===== src/lrcps_pixel_if.sv =====
// ----------------------------------------------------------------------------
// lrcps_pixel_if
// Pixel command channel: valid/ready handshake carrying one strip command.
// ----------------------------------------------------------------------------
interface lrcps_pixel_if;
  logic                              valid;
  logic                              ready;
  logic [lrcps_pkg::CMD_W-1:0]       command;
  logic [lrcps_pkg::PIX_W-1:0]       pixel_index;
  logic [lrcps_pkg::CHAN_W-1:0]      red;
  logic [lrcps_pkg::CHAN_W-1:0]      green;
  logic [lrcps_pkg::CHAN_W-1:0]      blue;

  modport source (output valid, output command, output pixel_index,
                  output red, output green, output blue, input ready);
  modport sink   (input valid, input command, input pixel_index,
                  input red, input green, input blue, output ready);
endinterface

// ===== src/led_ring_chase_pattern_sequencer.sv =====
// ----------------------------------------------------------------------------
// led_ring_chase_pattern_sequencer
// Steps a chase / hold / off test pattern over an LED ring from timestamps.
//
//   channel  dir  handshake        payload
//   tick     in   valid / ready    now_ms
//   pixel    out  valid / ready    command, pixel_index, red, green, blue
//   cfg      in   cfg_we           cfg_index, cfg_data
//
// Each timestamp item is decoded in the cycle it is accepted and its single
// result appears in the output register on the next cycle: one item per clock
// unless stalled. The output register is the only buffer; tick.ready is low
// only while a result is held and pixel.ready is low. Reset restores the
// default registers, chase phase, pixel 0, colour 0; no clearing pass.
// ----------------------------------------------------------------------------
module led_ring_chase_pattern_sequencer (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [lrcps_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lrcps_pkg::CFG_W-1:0]          cfg_data,
  lrcps_tick_if.sink                           tick,
  lrcps_pixel_if.source                        pixel
);

  typedef enum logic [1:0] {
    PH_CHASE = 2'd0,
    PH_HOLD  = 2'd1,
    PH_OFF   = 2'd2
  } phase_t;

  localparam logic [lrcps_pkg::CIDX_W-1:0] LAST_COLOUR =
    lrcps_pkg::CIDX_W'(lrcps_pkg::PALETTE_ENTRIES - 1);

  // configuration registers
  logic [lrcps_pkg::PIX_W-1:0]   led_count;
  logic [lrcps_pkg::DELAY_W-1:0] chase_delay_ms;
  logic [lrcps_pkg::DELAY_W-1:0] hold_delay_ms;
  logic [lrcps_pkg::DELAY_W-1:0] off_delay_ms;

  // sequencer state
  phase_t                         phase, phase_next;
  logic [lrcps_pkg::PIX_W-1:0]    next_pixel, next_pixel_next;
  logic [lrcps_pkg::CIDX_W-1:0]   colour_index, colour_index_next;
  logic [lrcps_pkg::TIME_W-1:0]   last_step_time, last_step_time_next;
  logic [lrcps_pkg::TIME_W-1:0]   phase_start_time, phase_start_time_next;

  // result
  logic                           out_valid;
  logic [lrcps_pkg::CMD_W-1:0]    command_next;
  logic [lrcps_pkg::PIX_W-1:0]    pixel_index_next;
  lrcps_pkg::colour_t             colour_next;

  logic                           take;
  logic [lrcps_pkg::TIME_W-1:0]   since, delay, elapsed_ms;
  logic                           due;
  logic [lrcps_pkg::PIX_W-1:0]    pixel_inc;
  lrcps_pkg::colour_t             colour_cur;

  assign tick.ready = !out_valid || pixel.ready;
  assign take       = tick.valid && tick.ready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      led_count      <= 8'd12;
      chase_delay_ms <= 16'd50;
      hold_delay_ms  <= 16'd500;
      off_delay_ms   <= 16'd250;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lrcps_pkg::REG_LED_COUNT:   led_count      <= cfg_data[lrcps_pkg::PIX_W-1:0];
        lrcps_pkg::REG_CHASE_DELAY: chase_delay_ms <= cfg_data;
        lrcps_pkg::REG_HOLD_DELAY:  hold_delay_ms  <= cfg_data;
        lrcps_pkg::REG_OFF_DELAY:   off_delay_ms   <= cfg_data;
        default: ;
      endcase
    end
  end

  // elapsed time check for the current phase, wraps modulo 2^32
  always_comb begin
    case (phase)
      PH_HOLD: begin
        since = phase_start_time;
        delay = lrcps_pkg::TIME_W'(hold_delay_ms);
      end
      PH_OFF: begin
        since = phase_start_time;
        delay = lrcps_pkg::TIME_W'(off_delay_ms);
      end
      default: begin
        since = last_step_time;
        delay = lrcps_pkg::TIME_W'(chase_delay_ms);
      end
    endcase
    elapsed_ms = tick.now_ms - since;
    due        = (led_count != '0) && (elapsed_ms >= delay);
  end

  assign pixel_inc  = next_pixel + 1'b1;
  assign colour_cur = lrcps_pkg::palette(colour_index);

  // next state and result
  always_comb begin
    phase_next            = phase;
    next_pixel_next       = next_pixel;
    colour_index_next     = colour_index;
    last_step_time_next   = last_step_time;
    phase_start_time_next = phase_start_time;
    command_next          = lrcps_pkg::CMD_NONE;
    pixel_index_next      = '0;
    colour_next           = '0;
    if (due) begin
      unique case (phase)
        PH_HOLD: begin
          command_next          = lrcps_pkg::CMD_CLEAR;
          phase_next            = PH_OFF;
          phase_start_time_next = tick.now_ms;
        end
        PH_OFF: begin
          colour_index_next   = (colour_index >= LAST_COLOUR) ? '0 : colour_index + 1'b1;
          phase_next          = PH_CHASE;
          next_pixel_next     = '0;
          last_step_time_next = tick.now_ms;
        end
        default: begin
          // chase step, unused phase code behaves the same
          last_step_time_next = tick.now_ms;
          command_next        = lrcps_pkg::CMD_SET;
          pixel_index_next    = next_pixel;
          colour_next         = colour_cur;
          next_pixel_next     = pixel_inc;
          if (pixel_inc == '0 || pixel_inc >= led_count) begin
            phase_next            = PH_HOLD;
            phase_start_time_next = tick.now_ms;
          end
        end
      endcase
    end
  end

  // state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_CHASE;
      next_pixel        <= '0;
      colour_index      <= '0;
      last_step_time    <= '0;
      phase_start_time  <= '0;
      out_valid         <= 1'b0;
      pixel.command     <= lrcps_pkg::CMD_NONE;
      pixel.pixel_index <= '0;
      pixel.red         <= '0;
      pixel.green       <= '0;
      pixel.blue        <= '0;
    end else begin
      if (take) begin
        phase             <= phase_next;
        next_pixel        <= next_pixel_next;
        colour_index      <= colour_index_next;
        last_step_time    <= last_step_time_next;
        phase_start_time  <= phase_start_time_next;
        out_valid         <= 1'b1;
        pixel.command     <= command_next;
        pixel.pixel_index <= pixel_index_next;
        pixel.red         <= colour_next.red;
        pixel.green       <= colour_next.green;
        pixel.blue        <= colour_next.blue;
      end else if (pixel.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign pixel.valid = out_valid;

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the LED ring chase pattern sequencer. Timestamp
// items are fed over the tick channel and every pixel command that comes back
// is compared with a cycle-free model of the chase / hold / off pattern kept
// in a scoreboard. A directed opening covers the edges of the delays and the
// pixel count; random phases then vary the registers, timestamp steps and
// handshake back-pressure.
// ----------------------------------------------------------------------------
module tb_top;
  import lrcps_pkg::*;

  localparam int unsigned RANDOM_ITEMS     = 1250;
  localparam longint      RUN_LIMIT_CYCLES = 400000;
  localparam int unsigned MAX_REPORTS      = 40;

  typedef enum logic [1:0] {
    PH_CHASE = 2'd0,
    PH_HOLD  = 2'd1,
    PH_OFF   = 2'd2
  } ring_phase_e;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [PIX_W-1:0] pixel_index;
    colour_t          colour;
  } pixel_cmd_t;

  // pattern model and queue of pixel commands still to come back
  class chase_scoreboard;
    logic [PIX_W-1:0]   led_count;
    logic [DELAY_W-1:0] chase_ms;
    logic [DELAY_W-1:0] hold_ms;
    logic [DELAY_W-1:0] off_ms;
    ring_phase_e        phase;
    logic [PIX_W-1:0]   next_pixel;
    logic [CIDX_W-1:0]  colour_idx;
    logic [TIME_W-1:0]  last_step;
    logic [TIME_W-1:0]  phase_start;
    pixel_cmd_t         expected_cmds[$];
    int unsigned        errors;

    function new();
      led_count   = 8'd12;
      chase_ms    = 16'd50;
      hold_ms     = 16'd500;
      off_ms      = 16'd250;
      phase       = PH_CHASE;
      next_pixel  = '0;
      colour_idx  = '0;
      last_step   = '0;
      phase_start = '0;
      errors      = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_LED_COUNT:   led_count = data[PIX_W-1:0];
        REG_CHASE_DELAY: chase_ms  = data[DELAY_W-1:0];
        REG_HOLD_DELAY:  hold_ms   = data[DELAY_W-1:0];
        REG_OFF_DELAY:   off_ms    = data[DELAY_W-1:0];
        default: ;
      endcase
    endfunction

    function colour_t colour_for(logic [CIDX_W-1:0] idx);
      colour_t c;
      case (idx)
        3'd0:    c = {8'd255, 8'd32,  8'd32};
        3'd1:    c = {8'd32,  8'd255, 8'd80};
        3'd2:    c = {8'd32,  8'd64,  8'd255};
        3'd3:    c = {8'd255, 8'd180, 8'd32};
        3'd4:    c = {8'd255, 8'd32,  8'd180};
        3'd5:    c = {8'd32,  8'd255, 8'd255};
        3'd6:    c = {8'd255, 8'd255, 8'd255};
        default: c = '0;
      endcase
      return c;
    endfunction

    // wrapping elapsed-time test
    function bit elapsed(logic [TIME_W-1:0] now, logic [TIME_W-1:0] since,
                         logic [DELAY_W-1:0] delay);
      logic [TIME_W-1:0] diff;
      diff = now - since;
      return diff >= {{(TIME_W-DELAY_W){1'b0}}, delay};
    endfunction

    function pixel_cmd_t predict_step(logic [TIME_W-1:0] now);
      pixel_cmd_t res;
      res = '0;
      if (led_count != 0) begin
        case (phase)
          PH_HOLD: begin
            if (elapsed(now, phase_start, hold_ms)) begin
              res.command = CMD_CLEAR;
              phase       = PH_OFF;
              phase_start = now;
            end
          end
          PH_OFF: begin
            if (elapsed(now, phase_start, off_ms)) begin
              colour_idx = CIDX_W'((colour_idx + 1) % PALETTE_ENTRIES);
              phase      = PH_CHASE;
              next_pixel = '0;
              last_step  = now;
            end
          end
          default: begin
            if (elapsed(now, last_step, chase_ms)) begin
              last_step       = now;
              res.command     = CMD_SET;
              res.pixel_index = next_pixel;
              res.colour      = colour_for(colour_idx);
              next_pixel      = next_pixel + 1'b1;
              // ring complete, or the count was lowered under the cursor
              if (next_pixel == 0 || next_pixel >= led_count) begin
                phase       = PH_HOLD;
                phase_start = now;
              end
            end
          end
        endcase
      end
      return res;
    endfunction

    function void note_tick(logic [TIME_W-1:0] now);
      expected_cmds.push_back(predict_step(now));
    endfunction

    function void compare(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
      end
    endfunction

    function void check_pixel(pixel_cmd_t got);
      pixel_cmd_t want;
      if (expected_cmds.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: pixel item with nothing expected, expected none, got command %0d",
                   $time, got.command);
        return;
      end
      want = expected_cmds.pop_front();
      compare("command", want.command, got.command);
      compare("pixel_index", want.pixel_index, got.pixel_index);
      compare("red", want.colour.red, got.colour.red);
      compare("green", want.colour.green, got.colour.green);
      compare("blue", want.colour.blue, got.colour.blue);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  lrcps_tick_if  tick_ch ();
  lrcps_pixel_if pix_ch ();

  chase_scoreboard sb = new();

  int unsigned send_idle  = 0;
  int unsigned recv_stall = 0;
  logic [TIME_W-1:0] cur_ms;

  led_ring_chase_pattern_sequencer DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .tick      (tick_ch),
    .pixel     (pix_ch)
  );

  // clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // pixel channel back-pressure
  always @(posedge clk) begin
    pix_ch.ready <= ($urandom_range(0, 99) >= recv_stall);
  end

  // watch both channels
  always @(posedge clk) begin : watch
    pixel_cmd_t got;
    if (!rst) begin
      if (tick_ch.valid && tick_ch.ready)
        sb.note_tick(tick_ch.now_ms);
      if (pix_ch.valid && pix_ch.ready) begin
        got.command     = pix_ch.command;
        got.pixel_index = pix_ch.pixel_index;
        got.colour      = {pix_ch.red, pix_ch.green, pix_ch.blue};
        sb.check_pixel(got);
      end
    end
  end

  // one timestamp item, with random idle cycles in front
  task automatic send_tick(input logic [TIME_W-1:0] t);
    while ($urandom_range(0, 99) < send_idle) begin
      tick_ch.valid <= 1'b0;
      @(posedge clk);
    end
    tick_ch.valid  <= 1'b1;
    tick_ch.now_ms <= t;
    do @(posedge clk); while (!tick_ch.ready);
  endtask

  // stop sending and wait for every pixel command to come back
  task automatic drain_results();
    tick_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_cmds.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // write all four registers back to back
  task automatic write_config(input logic [CFG_W-1:0] lc, input logic [CFG_W-1:0] cd,
                              input logic [CFG_W-1:0] hd, input logic [CFG_W-1:0] od);
    logic [CFG_W-1:0]     vals [4];
    logic [CFG_IDX_W-1:0] regs [4];
    vals = '{lc, cd, hd, od};
    regs = '{REG_LED_COUNT, REG_CHASE_DELAY, REG_HOLD_DELAY, REG_OFF_DELAY};
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= regs[i];
      cfg_data  <= vals[i];
      @(posedge clk);
      sb.write_reg(regs[i], vals[i]);
    end
    cfg_we <= 1'b0;
  endtask

  // run limit
  initial begin
    #(RUN_LIMIT_CYCLES * 12);
    $display("tb_top NOT OK");
    $finish;
  end

  initial begin : stimulus
    int unsigned done_items;
    int unsigned phase_no;
    int unsigned n;
    int unsigned smax;
    int unsigned kind;
    int unsigned pick;
    logic [CFG_W-1:0] lc, cd, hd, od;

    rst            <= 1'b1;
    cfg_we         <= 1'b0;
    cfg_index      <= REG_LED_COUNT;
    cfg_data       <= '0;
    tick_ch.valid  <= 1'b0;
    tick_ch.now_ms <= '0;
    cur_ms = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset registers: not yet elapsed, then exactly elapsed
    send_tick(32'd0);
    send_tick(32'd49);
    send_tick(32'd50);
    send_tick(32'd99);
    send_tick(32'd100);

    // zero leds, junk in the upper data byte
    drain_results();
    write_config(16'hA500, 16'd50, 16'd500, 16'd250);
    send_tick(32'hFFFF_FFFF);
    send_tick(32'h1234_5678);

    // zero delays: last pixel, clear and colour change on one timestamp
    drain_results();
    write_config(16'd3, 16'd0, 16'd0, 16'd0);
    send_tick(32'd200);
    send_tick(32'd200);
    send_tick(32'd200);
    send_tick(32'd201);

    // largest delays, one short and one exact
    drain_results();
    write_config(16'd2, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_tick(32'd201 + 32'd65534);
    send_tick(32'd201 + 32'd65535);
    send_tick(32'd65736 + 32'd65534);
    send_tick(32'd65736 + 32'd65535);

    // elapsed time across the timestamp wrap
    drain_results();
    write_config(16'd8, 16'd10, 16'd0, 16'd0);
    send_tick(32'hFFFF_FFF8);
    send_tick(32'd1);
    send_tick(32'd2);
    send_tick(32'd12);
    send_tick(32'd22);
    send_tick(32'd32);

    // count lowered under the next pixel mid chase
    drain_results();
    write_config(16'd2, 16'd10, 16'd0, 16'd0);
    send_tick(32'd42);
    send_tick(32'd42);

    // random phases
    done_items = 0;
    phase_no   = 0;
    cur_ms     = 32'd42;
    while (done_items < RANDOM_ITEMS) begin
      kind = (phase_no < 6) ? phase_no : $urandom_range(0, 9);
      n  = $urandom_range(60, 140);
      lc = CFG_W'($urandom_range(1, 8));
      cd = CFG_W'($urandom_range(0, 10));
      hd = CFG_W'($urandom_range(0, 10));
      od = CFG_W'($urandom_range(0, 10));
      case (kind)
        0: begin
          lc = '0;
          n  = 20;
        end
        1: begin
          lc = 16'd255;
          cd = CFG_W'($urandom_range(0, 1));
          n  = 300;
        end
        2: begin
          lc = CFG_W'($urandom_range(1, 4));
          cd = 16'hFFFF;
          hd = 16'hFFFF;
          od = 16'hFFFF;
        end
        3: begin
          lc = CFG_W'($urandom_range(1, 16));
          cd = '0;
          hd = '0;
          od = '0;
        end
        4: begin
          cd = CFG_W'($urandom);
          hd = CFG_W'($urandom);
          od = CFG_W'($urandom);
        end
        default: ;
      endcase
      if ($urandom_range(0, 1) != 0)
        lc[CFG_W-1:PIX_W] = (CFG_W-PIX_W)'($urandom);
      smax = cd;
      if (hd > smax) smax = hd;
      if (od > smax) smax = od;
      smax += 2;

      drain_results();
      case (phase_no % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 72; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 72; end
        default: begin send_idle = 29; recv_stall = 29; end
      endcase
      write_config(lc, cd, hd, od);
      if ($urandom_range(0, 3) == 0)
        cur_ms = 32'hFFFF_FFFF - $urandom_range(0, 200);

      // mostly forward steps near the delays, some jumps and rewinds
      for (int i = 0; i < n; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 80)
          cur_ms = cur_ms + $urandom_range(0, smax);
        else if (pick < 88)
          cur_ms = $urandom;
        else if (pick < 95)
          cur_ms = cur_ms - $urandom_range(1, 20);
        else
          cur_ms = cur_ms + $urandom;
        send_tick(cur_ms);
      end
      if (lc[PIX_W-1:0] != 0)
        done_items += n;
      phase_no++;
    end

    drain_results();
    repeat (4) @(posedge clk);
    if (sb.errors == 0 && sb.expected_cmds.size() == 0)
      $display("tb_top OK");
    else
      $display("tb_top NOT OK");
    $finish;
  end

endmodule
